[hdl/pcac_pkg.sv]
// shared types and constants of the per-channel autocorrelation accumulator
package pcac_pkg;

	localparam int NUM_CHANNELS_DEF = 2048;
	localparam int NUM_SAMPLES_DEF  = 32;

	localparam int MAX_GAIN = 3;
	localparam int PERCENT  = 100;

	// floor(x / 100) as (x * RECIP) >> RECIP_SHIFT, exact for x below 2**23
	localparam int RECIP_SHIFT = 30;
	localparam logic [23:0] RECIP = 24'd10737419;

	localparam logic [15:0] TPS_RESET  = 16'd100;
	localparam logic [6:0]  DROP_RESET = 7'd10;

	localparam logic [1:0] CFG_TPS  = 2'd0;
	localparam logic [1:0] CFG_DROP = 2'd1;
	localparam logic [1:0] CFG_SC   = 2'd2;

	localparam logic STATUS_STEP = 1'b0;
	localparam logic STATUS_BAD_GAIN = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_DECIDE,
		ST_MAC_RD,
		ST_MAC_MUL,
		ST_MAC_WR,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_ERR
	} state_t;

	typedef struct packed {
		logic clr_wr;
		logic accept;
		logic decide;
		logic mac_wr;
		logic emit_sel;
		logic emit_ld;
		logic err_ld;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic go_look;
		logic go_err;
		logic emit;
		logic mac_done;
		logic emit_last;
	} status_t;

endpackage

[hdl/pcac_ram.sv]
// generic single-write, single-read ram with registered read data
module pcac_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = pcac_pkg::NUM_SAMPLES_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic [AW-1:0]        raddr,
	output logic [WIDTH-1:0]     rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[hdl/pcac_ctrl.sv]
// controller state machine of the accumulator
module pcac_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  pcac_pkg::status_t  st,
	output pcac_pkg::cmd_t     cmd,
	output logic               busy
);
	pcac_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcac_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			pcac_pkg::ST_CLEAR: begin
				if (st.clr_last) state_d = pcac_pkg::ST_IDLE;
			end
			pcac_pkg::ST_IDLE: begin
				if (start) begin
					if (st.go_err) state_d = pcac_pkg::ST_ERR;
					else if (st.go_look) state_d = pcac_pkg::ST_LOOK;
				end
			end
			pcac_pkg::ST_LOOK:    state_d = pcac_pkg::ST_DECIDE;
			pcac_pkg::ST_DECIDE:  state_d = pcac_pkg::ST_MAC_RD;
			pcac_pkg::ST_MAC_RD:  state_d = pcac_pkg::ST_MAC_MUL;
			pcac_pkg::ST_MAC_MUL: state_d = pcac_pkg::ST_MAC_WR;
			pcac_pkg::ST_MAC_WR: begin
				if (!st.mac_done) state_d = pcac_pkg::ST_MAC_RD;
				else if (st.emit) state_d = pcac_pkg::ST_EMIT_RD;
				else state_d = pcac_pkg::ST_IDLE;
			end
			pcac_pkg::ST_EMIT_RD: state_d = pcac_pkg::ST_EMIT_LD;
			pcac_pkg::ST_EMIT_LD: begin
				if (st.emit_last) state_d = pcac_pkg::ST_IDLE;
				else state_d = pcac_pkg::ST_EMIT_RD;
			end
			pcac_pkg::ST_ERR:     state_d = pcac_pkg::ST_IDLE;
			default:              state_d = pcac_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			pcac_pkg::ST_CLEAR:   cmd.clr_wr = 1'b1;
			pcac_pkg::ST_IDLE:    cmd.accept = start;
			pcac_pkg::ST_DECIDE:  cmd.decide = 1'b1;
			pcac_pkg::ST_MAC_WR:  cmd.mac_wr = 1'b1;
			pcac_pkg::ST_EMIT_RD: cmd.emit_sel = 1'b1;
			pcac_pkg::ST_EMIT_LD: begin
				cmd.emit_sel = 1'b1;
				cmd.emit_ld = 1'b1;
			end
			pcac_pkg::ST_ERR:     cmd.err_ld = 1'b1;
			default:              cmd = '0;
		endcase
	end

	assign busy = (state_q != pcac_pkg::ST_IDLE);
endmodule

[hdl/pcac_dp.sv]
// datapath: config, digit buffer, per-channel stores, multiply-accumulate, result regs
module pcac_dp #(
	parameter int NUM_CHANNELS = pcac_pkg::NUM_CHANNELS_DEF,
	parameter int NUM_SAMPLES  = pcac_pkg::NUM_SAMPLES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pcac_pkg::cmd_t      cmd,
	output pcac_pkg::status_t   st,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic [10:0]         channel_index,
	input  logic [2:0]          gain_code,
	input  logic signed [15:0]  sample_value,
	input  logic                last_sample,
	output logic                result_strobe,
	output logic [10:0]         out_channel,
	output logic [2:0]          out_gain,
	output logic [5:0]          sample_index,
	output logic signed [31:0]  sample_sum,
	output logic signed [63:0]  lag_sum,
	output logic [15:0]         triggers_used,
	output logic                status,
	output logic                last_result
);
	localparam int CAW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int SDEPTH = NUM_CHANNELS * NUM_SAMPLES;
	localparam int SAW = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
	localparam int IW = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;
	localparam int NW = $clog2(NUM_SAMPLES + 1);
	localparam logic [NW-1:0] NS_N = NW'(NUM_SAMPLES);
	localparam logic [SAW-1:0] NS_A = SAW'(NUM_SAMPLES);

	// configuration registers
	logic [15:0] tps_q;
	logic [6:0]  drop_q;
	logic        sc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= pcac_pkg::TPS_RESET;
			drop_q <= pcac_pkg::DROP_RESET;
			sc_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				pcac_pkg::CFG_TPS:  tps_q <= cfg_data;
				pcac_pkg::CFG_DROP: drop_q <= cfg_data[6:0];
				pcac_pkg::CFG_SC:   sc_q <= cfg_data[0];
				default:            tps_q <= tps_q;
			endcase
		end
	end

	// dropped triggers: (tps * min(drop,100)) / 100 over two stages
	logic [6:0]  drop_cl;
	logic [22:0] prod_s1;
	logic [46:0] recip_prod;
	logic [15:0] quot_s2;

	assign drop_cl = (drop_q > 7'(pcac_pkg::PERCENT)) ? 7'(pcac_pkg::PERCENT) : drop_q;
	assign recip_prod = 47'(prod_s1) * 47'(pcac_pkg::RECIP);

	always_ff @(posedge clk) begin
		prod_s1 <= 23'(tps_q) * 23'(drop_cl);
		quot_s2 <= 16'(recip_prod >> pcac_pkg::RECIP_SHIFT);
	end

	// digit capture
	logic [NW-1:0]  fill_q, fill_next;
	logic           inv_q, inv_now;
	logic [10:0]    ch_q;
	logic [2:0]     gain_q;
	logic [NW-1:0]  n_q;
	logic [SAW-1:0] base_q;
	logic           buf_we;

	assign inv_now = inv_q | sample_value[15];
	assign buf_we = cmd.accept && (fill_q < NS_N);
	assign fill_next = buf_we ? fill_q + NW'(1) : fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			inv_q <= 1'b0;
		end else if (cmd.accept) begin
			if (last_sample) begin
				fill_q <= '0;
				inv_q <= 1'b0;
			end else begin
				fill_q <= fill_next;
				inv_q <= inv_now;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && last_sample) begin
			ch_q <= channel_index;
			gain_q <= gain_code;
			n_q <= fill_next;
			base_q <= SAW'(channel_index) * NS_A;
		end
	end

	logic skip_digit;
	assign skip_digit = sc_q && inv_now;
	assign st.go_err = last_sample && !skip_digit && (gain_code > 3'(pcac_pkg::MAX_GAIN));
	assign st.go_look = last_sample && !skip_digit &&
		(gain_code <= 3'(pcac_pkg::MAX_GAIN)) && (32'(channel_index) < NUM_CHANNELS);

	// clearing pass over the trigger counts
	logic [CAW-1:0] clr_q;
	assign st.clr_last = (clr_q == CAW'(NUM_CHANNELS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= clr_q + CAW'(1);
		end
	end

	// per-channel stores
	logic [15:0]    trig_rd, trig_wd;
	logic [CAW-1:0] trig_wa;
	logic [NW-1:0]  sid_rd;
	logic           first;
	logic [16:0]    cnt;
	logic [NW-1:0]  m_cur, neff;
	logic [15:0]    tgt_raw, tgt;
	logic           emit_now;

	assign cnt = 17'(trig_rd) + 17'd1;
	assign first = (trig_rd == 16'd0);
	assign m_cur = first ? n_q : sid_rd;
	assign neff = (n_q < m_cur) ? n_q : m_cur;
	assign tgt_raw = sc_q ? (tps_q - quot_s2) : tps_q;
	assign tgt = (tgt_raw == 16'd0) ? 16'd1 : tgt_raw;
	assign emit_now = (cnt >= 17'(tgt));
	assign trig_wa = cmd.clr_wr ? clr_q : CAW'(ch_q);
	assign trig_wd = (cmd.clr_wr || emit_now) ? 16'd0 : cnt[15:0];

	pcac_ram #(.WIDTH(16), .DEPTH(NUM_CHANNELS)) u_trig (
		.clk(clk), .we(cmd.clr_wr || cmd.decide), .waddr(trig_wa), .wdata(trig_wd),
		.raddr(CAW'(ch_q)), .rdata(trig_rd)
	);

	pcac_ram #(.WIDTH(NW), .DEPTH(NUM_CHANNELS)) u_sid (
		.clk(clk), .we(cmd.decide && first), .waddr(CAW'(ch_q)), .wdata(n_q),
		.raddr(CAW'(ch_q)), .rdata(sid_rd)
	);

	logic           first_q, emit_q;
	logic [NW-1:0]  m_q, neff_q;
	logic [15:0]    cnt_q;
	logic [IW-1:0]  j_q, k_q;
	logic           k_last, j_last, e_last;

	assign k_last = (NW'(k_q) + NW'(1)) == neff_q;
	assign j_last = (NW'(j_q) + NW'(1)) == neff_q;
	assign e_last = (NW'(j_q) + NW'(1)) == m_q;
	assign st.emit = emit_q;
	assign st.mac_done = k_last && j_last;
	assign st.emit_last = e_last;

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			first_q <= first;
			emit_q <= emit_now;
			m_q <= m_cur;
			neff_q <= neff;
			cnt_q <= cnt[15:0];
			j_q <= '0;
			k_q <= '0;
		end else if (cmd.mac_wr) begin
			if (k_last) begin
				if (j_last) begin
					j_q <= '0;
				end else begin
					j_q <= j_q + IW'(1);
					k_q <= j_q + IW'(1);
				end
			end else begin
				k_q <= k_q + IW'(1);
			end
		end else if (cmd.emit_ld) begin
			j_q <= j_q + IW'(1);
		end
	end

	// digit buffer, one copy per read port
	logic [15:0] bufj_rd, bufk_rd;

	pcac_ram #(.WIDTH(16), .DEPTH(NUM_SAMPLES)) u_bufj (
		.clk(clk), .we(buf_we), .waddr(fill_q[IW-1:0]), .wdata(sample_value),
		.raddr(j_q), .rdata(bufj_rd)
	);

	pcac_ram #(.WIDTH(16), .DEPTH(NUM_SAMPLES)) u_bufk (
		.clk(clk), .we(buf_we), .waddr(fill_q[IW-1:0]), .wdata(sample_value),
		.raddr(k_q), .rdata(bufk_rd)
	);

	// sums
	logic [IW-1:0]       lag_idx;
	logic [SAW-1:0]      pos_addr, lag_addr;
	logic [31:0]         pos_rd, pos_wd;
	logic [63:0]         lag_rd, lag_wd;
	logic signed [31:0]  mul_s1;

	assign lag_idx = cmd.emit_sel ? j_q : (k_q - j_q);
	assign pos_addr = base_q + SAW'(j_q);
	assign lag_addr = base_q + SAW'(lag_idx);

	always_ff @(posedge clk) begin
		mul_s1 <= $signed(bufj_rd) * $signed(bufk_rd);
	end

	assign pos_wd = (first_q ? 32'd0 : pos_rd) + 32'($signed(bufj_rd));
	assign lag_wd = ((first_q && (j_q == '0)) ? 64'd0 : lag_rd) + 64'(mul_s1);

	pcac_ram #(.WIDTH(32), .DEPTH(SDEPTH)) u_pos (
		.clk(clk), .we(cmd.mac_wr && (j_q == k_q)), .waddr(pos_addr), .wdata(pos_wd),
		.raddr(pos_addr), .rdata(pos_rd)
	);

	pcac_ram #(.WIDTH(64), .DEPTH(SDEPTH)) u_lag (
		.clk(clk), .we(cmd.mac_wr), .waddr(lag_addr), .wdata(lag_wd),
		.raddr(lag_addr), .rdata(lag_rd)
	);

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= cmd.emit_ld || cmd.err_ld;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_ld) begin
			out_channel <= ch_q;
			out_gain <= gain_q;
			sample_index <= 6'(j_q);
			sample_sum <= pos_rd;
			lag_sum <= lag_rd;
			triggers_used <= cnt_q;
			status <= pcac_pkg::STATUS_STEP;
			last_result <= e_last;
		end else if (cmd.err_ld) begin
			out_channel <= ch_q;
			out_gain <= gain_q;
			sample_index <= '0;
			sample_sum <= '0;
			lag_sum <= '0;
			triggers_used <= '0;
			status <= pcac_pkg::STATUS_BAD_GAIN;
			last_result <= 1'b1;
		end
	end
endmodule

[hdl/per_channel_autocorr_accumulator_core.sv]
// top level of the per-channel lagged autocorrelation accumulator
//
// usage
// - a request (one sample of a digit) is taken at a rising edge with start
//   high and busy low; channel_index, gain_code and last_sample ride along
// - samples that are not the last of a digit are only buffered, and
//   busy stays low between them
// - the last sample starts the digit's work: lookup (LOOK, DECIDE), then
//   the lag products, each through MAC_RD, MAC_MUL and MAC_WR; n*(n+1)/2
//   products, n the lesser of this digit's and the step's first digit's
//   sample counts, all on one shared multiply-accumulate unit with a
//   read-modify-write of the lag sum memory
// - once the channel's trigger count reaches its target, the step gives
//   one result per sample position, each through EMIT_RD and EMIT_LD, on
//   result_strobe for exactly one cycle each; the receiver cannot stall,
//   results are simply presented
// - a bad gain gives one error result, loaded in state ERR and strobed from
//   a register; skipped digits and out-of-range channels stay idle
// - after reset the trigger counts are cleared one channel a cycle, over
//   all NUM_CHANNELS channels, with busy high; config writes work throughout
// - config registers: write cfg_we with cfg_index and cfg_data, only idle
module per_channel_autocorr_accumulator_core #(
	parameter int NUM_CHANNELS = pcac_pkg::NUM_CHANNELS_DEF,
	parameter int NUM_SAMPLES  = pcac_pkg::NUM_SAMPLES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic                start,
	output logic                busy,
	input  logic [10:0]         channel_index,
	input  logic [2:0]          gain_code,
	input  logic signed [15:0]  sample_value,
	input  logic                last_sample,
	output logic                result_strobe,
	output logic [10:0]         out_channel,
	output logic [2:0]          out_gain,
	output logic [5:0]          sample_index,
	output logic signed [31:0]  sample_sum,
	output logic signed [63:0]  lag_sum,
	output logic [15:0]         triggers_used,
	output logic                status,
	output logic                last_result
);
	// command and status between the controller and the datapath
	pcac_pkg::cmd_t    cmd;
	pcac_pkg::status_t st;

	// sequencing: clear pass, capture, lookup, multiply-accumulate, emit
	pcac_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.st(st),
		.cmd(cmd),
		.busy(busy)
	);

	// storage, arithmetic and result registers
	pcac_dp #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.NUM_SAMPLES(NUM_SAMPLES)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.st(st),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.channel_index(channel_index),
		.gain_code(gain_code),
		.sample_value(sample_value),
		.last_sample(last_sample),
		.result_strobe(result_strobe),
		.out_channel(out_channel),
		.out_gain(out_gain),
		.sample_index(sample_index),
		.sample_sum(sample_sum),
		.lag_sum(lag_sum),
		.triggers_used(triggers_used),
		.status(status),
		.last_result(last_result)
	);
endmodule
